// ----- rtl/core/lcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, step counts, brand codes and digit helpers of the card
// number classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

	localparam int CARD_W        = 63;
	localparam int DIGITS        = 20;
	localparam int BCD_W         = DIGITS * 4;
	localparam int BITS_PER_STEP = 3;
	localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
	localparam int SCAN_STEPS    = DIGITS / 2;
	localparam int STEP_W        = $clog2(CONV_STEPS);
	localparam int COUNT_W       = 5;
	localparam int PREFIX_W      = 7;
	localparam int REM_W         = 4;
	localparam int BRAND_W       = 2;

	localparam logic [BRAND_W-1:0] BRAND_INVALID = 2'd0;
	localparam logic [BRAND_W-1:0] BRAND_LEN15   = 2'd1;
	localparam logic [BRAND_W-1:0] BRAND_LEN16   = 2'd2;
	localparam logic [BRAND_W-1:0] BRAND_FOUR    = 2'd3;

	localparam logic [COUNT_W-1:0]  LEN_13       = 5'd13;
	localparam logic [COUNT_W-1:0]  LEN_15       = 5'd15;
	localparam logic [COUNT_W-1:0]  LEN_16       = 5'd16;
	localparam logic [PREFIX_W-1:0] PFX_34       = 7'd34;
	localparam logic [PREFIX_W-1:0] PFX_37       = 7'd37;
	localparam logic [PREFIX_W-1:0] PFX_51       = 7'd51;
	localparam logic [PREFIX_W-1:0] PFX_55       = 7'd55;
	localparam logic [PREFIX_W-1:0] PFX_FOUR     = 7'd4;
	localparam logic [3:0]          DIGIT_FOUR   = 4'd4;

	typedef struct packed {
		logic load;
		logic conv;
		logic scan;
		logic out_load;
	} lcc_cmd_t;

	// doubled digit folded back to one digit
	function automatic logic [3:0] luhn_double(input logic [3:0] d);
		logic [4:0] t;
		t = {d, 1'b0};
		if (t > 5'd9)
			t = t - 5'd9;
		return t[3:0];
	endfunction

	// leading two digits, or four when the first digit is four
	function automatic logic [PREFIX_W-1:0] lead_prefix(input logic [3:0] top,
		input logic [3:0] second);
		logic [PREFIX_W-1:0] v;
		v = ({3'b000, top} * 7'd10) + {3'b000, second};
		if (top == DIGIT_FOUR)
			v = PFX_FOUR;
		return v;
	endfunction

	function automatic logic [BRAND_W-1:0] brand_of(input logic ok,
		input logic [COUNT_W-1:0] len, input logic [PREFIX_W-1:0] pfx);
		logic [BRAND_W-1:0] b;
		b = BRAND_INVALID;
		if (ok) begin
			if (len == LEN_15 && (pfx == PFX_34 || pfx == PFX_37))
				b = BRAND_LEN15;
			else if (len == LEN_16 && pfx >= PFX_51 && pfx <= PFX_55)
				b = BRAND_LEN16;
			else if ((len == LEN_13 || len == LEN_16) && pfx == PFX_FOUR)
				b = BRAND_FOUR;
		end
		return b;
	endfunction

endpackage

// ----- rtl/core/lcc_if.sv -----
// ----------------------------------------------------------------------------
// lcc channels
// Valid/ready channels for card numbers in and classification results out.
// ----------------------------------------------------------------------------
interface lcc_in_if;
	logic                        valid;
	logic                        ready;
	logic [lcc_pkg::CARD_W-1:0]  card_number;

	modport source(output valid, output card_number, input ready);
	modport sink(input valid, input card_number, output ready);
endinterface

interface lcc_out_if;
	logic                          valid;
	logic                          ready;
	logic [lcc_pkg::BRAND_W-1:0]   brand_class;
	logic                          luhn_ok;
	logic [lcc_pkg::REM_W-1:0]     luhn_remainder;
	logic [lcc_pkg::COUNT_W-1:0]   digit_count;
	logic [lcc_pkg::PREFIX_W-1:0]  leading_prefix;

	modport source(output valid, output brand_class, output luhn_ok,
		output luhn_remainder, output digit_count, output leading_prefix, input ready);
	modport sink(input valid, input brand_class, input luhn_ok,
		input luhn_remainder, input digit_count, input leading_prefix, output ready);
endinterface

// ----- rtl/core/lcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcc_ctrl
// Sequencer: accepts an item, runs the conversion and digit scan steps, then
// loads the result register once it is free.
// ----------------------------------------------------------------------------
module lcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output lcc_pkg::lcc_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} lcc_state_t;

	localparam logic [lcc_pkg::STEP_W-1:0] CONV_LAST = lcc_pkg::STEP_W'(lcc_pkg::CONV_STEPS - 1);
	localparam logic [lcc_pkg::STEP_W-1:0] SCAN_LAST = lcc_pkg::STEP_W'(lcc_pkg::SCAN_STEPS - 1);

	lcc_state_t                  state_q, state_d;
	logic [lcc_pkg::STEP_W-1:0]  step_q, step_d;
	logic                        out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				step_d   = step_q + 1'b1;
				if (step_q == CONV_LAST) begin
					step_d  = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				step_d   = step_q + 1'b1;
				if (step_q == SCAN_LAST) begin
					step_d  = '0;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// result register free or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				step_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/lcc_datapath.sv -----
// ----------------------------------------------------------------------------
// lcc_datapath
// Binary to decimal conversion three bits a step, then a digit scan two
// digits a step for the Luhn sum, digit count and leading prefix.
// ----------------------------------------------------------------------------
module lcc_datapath (
	input  logic                          clk,
	input  lcc_pkg::lcc_cmd_t             cmd,
	input  logic [lcc_pkg::CARD_W-1:0]    card_number,
	output logic [lcc_pkg::BRAND_W-1:0]   brand_class,
	output logic                          luhn_ok,
	output logic [lcc_pkg::REM_W-1:0]     luhn_remainder,
	output logic [lcc_pkg::COUNT_W-1:0]   digit_count,
	output logic [lcc_pkg::PREFIX_W-1:0]  leading_prefix
);

	logic [lcc_pkg::CARD_W-1:0]    bin_q, bin_nx;
	logic [lcc_pkg::BCD_W-1:0]     bcd_q, bcd_nx;
	logic [lcc_pkg::REM_W-1:0]     rem_q, rem_nx;
	logic [lcc_pkg::COUNT_W-1:0]   pos_q;
	logic [lcc_pkg::COUNT_W-1:0]   cnt_q, cnt_nx;
	logic [lcc_pkg::PREFIX_W-1:0]  pfx_q, pfx_nx;
	logic [3:0]                    prev_q;
	logic [3:0]                    lo, hi;
	logic [4:0]                    sum5;

	logic [lcc_pkg::BRAND_W-1:0]   brand_q;
	logic                          ok_q;
	logic [lcc_pkg::REM_W-1:0]     out_rem_q;
	logic [lcc_pkg::COUNT_W-1:0]   out_cnt_q;
	logic [lcc_pkg::PREFIX_W-1:0]  out_pfx_q;

	// shift-and-add-three, three bits per step
	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int s = 0; s < lcc_pkg::BITS_PER_STEP; s++) begin
			for (int d = 0; d < lcc_pkg::DIGITS; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5)
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
			end
			{bcd_nx, bin_nx} = {bcd_nx[lcc_pkg::BCD_W-2:0], bin_nx, 1'b0};
		end
	end

	// low digit at an even place, high digit at the next (doubled) place
	assign lo = bcd_q[3:0];
	assign hi = bcd_q[7:4];

	always_comb begin
		sum5 = {1'b0, rem_q} + {1'b0, lo} + {1'b0, lcc_pkg::luhn_double(hi)};
		if (sum5 >= 5'd20)
			sum5 = sum5 - 5'd20;
		else if (sum5 >= 5'd10)
			sum5 = sum5 - 5'd10;
		rem_nx = sum5[3:0];

		cnt_nx = cnt_q;
		pfx_nx = pfx_q;
		if (hi != 4'd0) begin
			cnt_nx = pos_q + 5'd2;
			pfx_nx = lcc_pkg::lead_prefix(hi, lo);
		end else if (lo != 4'd0) begin
			cnt_nx = pos_q + 5'd1;
			if (pos_q == '0)
				pfx_nx = {3'b000, lo};
			else
				pfx_nx = lcc_pkg::lead_prefix(lo, prev_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= card_number;
			bcd_q  <= '0;
			rem_q  <= '0;
			pos_q  <= '0;
			cnt_q  <= '0;
			pfx_q  <= '0;
			prev_q <= '0;
		end else if (cmd.conv) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
		end else if (cmd.scan) begin
			bcd_q  <= {8'h00, bcd_q[lcc_pkg::BCD_W-1:8]};
			rem_q  <= rem_nx;
			pos_q  <= pos_q + 5'd2;
			cnt_q  <= cnt_nx;
			pfx_q  <= pfx_nx;
			prev_q <= hi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			brand_q   <= lcc_pkg::brand_of(rem_q == '0, cnt_q, pfx_q);
			ok_q      <= (rem_q == '0);
			out_rem_q <= rem_q;
			out_cnt_q <= cnt_q;
			out_pfx_q <= pfx_q;
		end
	end

	assign brand_class    = brand_q;
	assign luhn_ok        = ok_q;
	assign luhn_remainder = out_rem_q;
	assign digit_count    = out_cnt_q;
	assign leading_prefix = out_pfx_q;

endmodule

// ----- rtl/core/luhn_card_number_classifier_core.sv -----
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_core
// Luhn mod-10 check with digit count, leading prefix and card brand class.
// ----------------------------------------------------------------------------
// card_in carries one 63-bit binary card number per item; result_out carries
// the brand class, Luhn pass flag, Luhn remainder, digit count and prefix.
// Both channels move an item when valid and ready are high at a clock edge.
// An item runs through the accept cycle, 21 steps of binary to decimal
// conversion at three bits a step, 10 digit scan steps at two digits a step,
// and a final state that loads the result register. The result is valid from
// the edge that ends that final state, and a new item is taken in the cycle
// after that, so the block takes no new item until the last result is loaded.
// The result sits in its own register: a stalled receiver does not hold up
// the work on the next item, only its final load into the result register.
// card_in.ready is high only while the sequencer is idle.
// Reset clears the sequencer and the result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier_core (
	input  logic       clk,
	input  logic       arst_n,
	lcc_in_if.sink     card_in,
	lcc_out_if.source  result_out
);

	lcc_pkg::lcc_cmd_t cmd;

	lcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (card_in.valid),
		.in_ready  (card_in.ready),
		.out_ready (result_out.ready),
		.out_valid (result_out.valid),
		.cmd       (cmd)
	);

	lcc_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.card_number    (card_in.card_number),
		.brand_class    (result_out.brand_class),
		.luhn_ok        (result_out.luhn_ok),
		.luhn_remainder (result_out.luhn_remainder),
		.digit_count    (result_out.digit_count),
		.leading_prefix (result_out.leading_prefix)
	);

	// only one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(card_in.valid && card_in.ready) |=> !card_in.ready)
		else $error("second item taken while one is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.luhn_ok) |->
		(result_out.brand_class == lcc_pkg::BRAND_INVALID))
		else $error("brand given to a number that fails the checksum");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.luhn_ok == (result_out.luhn_remainder == '0)))
		else $error("pass flag disagrees with remainder");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.digit_count == '0) |->
		(result_out.leading_prefix == '0 &&
		result_out.brand_class == lcc_pkg::BRAND_INVALID))
		else $error("zero number with a prefix or brand");

endmodule
